### hdl/sss_pkg.sv
// Shared constants, codes and control types for the signed subset-sum search block.
`default_nettype none
package sss_pkg;

	localparam int DEF_MAX_WEIGHTS = 16;
	localparam int DEF_WEIGHT_BITS = 16;
	localparam int WEIGHT_IN_W     = 16;
	localparam int TARGET_W        = 21;
	localparam int INDEX_W         = 4;
	localparam int COEF_W          = 2;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_SOLVE  = 2'd2;

	localparam logic [COEF_W-1:0] COEF_NEG  = 2'b11;
	localparam logic [COEF_W-1:0] COEF_ZERO = 2'b00;
	localparam logic [COEF_W-1:0] COEF_POS  = 2'b01;

	typedef struct packed {
		logic clear_list;
		logic append;
		logic solve_start;
		logic sweep_rd;
		logic sweep_wr;
		logic enter_rd;
		logic descend;
		logic back_rd;
		logic next_coef;
		logic undo;
		logic emit_start;
		logic emit_rd;
		logic load_found;
		logic load_fail;
	} sss_cmd_t;

	typedef struct packed {
		logic idx_zero;
		logic d_zero;
		logic at_end;
		logic gap_zero;
		logic prune;
		logic coef_pos;
		logic emit_last;
		logic out_free;
	} sss_stat_t;

endpackage
`default_nettype wire

### hdl/sss_ifs.sv
// Request and result channel interfaces of the signed subset-sum search block.
`default_nettype none
interface sss_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           command;
	logic [sss_pkg::WEIGHT_IN_W-1:0]      weight_value;
	logic signed [sss_pkg::TARGET_W-1:0]  target_mass;

	modport source (output valid, output command, output weight_value, output target_mass,
		input ready);
	modport sink (input valid, input command, input weight_value, input target_mass,
		output ready);
endinterface

interface sss_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic [sss_pkg::INDEX_W-1:0]        weight_index;
	logic signed [sss_pkg::COEF_W-1:0]  coefficient;
	logic                               last;

	modport source (output valid, output found, output weight_index, output coefficient,
		output last, input ready);
	modport sink (input valid, input found, input weight_index, input coefficient,
		input last, output ready);
endinterface
`default_nettype wire

### hdl/sss_ctrl.sv
// Controller state machine sequencing load, suffix-sum sweep, backtracking search and emission.
`default_nettype none
module sss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          in_command,
	input  wire sss_pkg::sss_stat_t  stat,
	output logic                     in_ready,
	output sss_pkg::sss_cmd_t        cmd
);
	import sss_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SWEEP_RD = 4'd1;
	localparam logic [3:0] S_SWEEP_WR = 4'd2;
	localparam logic [3:0] S_ENTER_RD = 4'd3;
	localparam logic [3:0] S_ENTER_EV = 4'd4;
	localparam logic [3:0] S_BACK_RD  = 4'd5;
	localparam logic [3:0] S_BACK_EV  = 4'd6;
	localparam logic [3:0] S_EMIT_RD  = 4'd7;
	localparam logic [3:0] S_EMIT_WR  = 4'd8;
	localparam logic [3:0] S_FAIL     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_command)
						CMD_CLEAR:  cmd.clear_list = 1'b1;
						CMD_APPEND: cmd.append = 1'b1;
						CMD_SOLVE: begin
							cmd.solve_start = 1'b1;
							state_nx        = S_SWEEP_RD;
						end
						default: ;
					endcase
				end
			end
			S_SWEEP_RD: begin
				if (stat.idx_zero) begin
					state_nx = S_ENTER_RD;
				end else begin
					cmd.sweep_rd = 1'b1;
					state_nx     = S_SWEEP_WR;
				end
			end
			S_SWEEP_WR: begin
				cmd.sweep_wr = 1'b1;
				state_nx     = S_SWEEP_RD;
			end
			S_ENTER_RD: begin
				cmd.enter_rd = 1'b1;
				state_nx     = S_ENTER_EV;
			end
			S_ENTER_EV: begin
				if (stat.at_end) begin
					if (stat.gap_zero) begin
						cmd.emit_start = 1'b1;
						state_nx       = S_EMIT_RD;
					end else begin
						state_nx = S_BACK_RD;
					end
				end else if (stat.prune) begin
					state_nx = S_BACK_RD;
				end else begin
					cmd.descend = 1'b1;
					state_nx    = S_ENTER_RD;
				end
			end
			S_BACK_RD: begin
				if (stat.d_zero) begin
					state_nx = S_FAIL;
				end else begin
					cmd.back_rd = 1'b1;
					state_nx    = S_BACK_EV;
				end
			end
			S_BACK_EV: begin
				if (stat.coef_pos) begin
					cmd.undo = 1'b1;
					state_nx = S_BACK_RD;
				end else begin
					cmd.next_coef = 1'b1;
					state_nx      = S_ENTER_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_nx    = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (stat.out_free) begin
					cmd.load_found = 1'b1;
					state_nx       = stat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_FAIL: begin
				if (stat.out_free) begin
					cmd.load_fail = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

### hdl/sss_dp.sv
// Datapath: weight, suffix-sum and coefficient memories, search registers and result register.
`default_nettype none
module sss_dp #(
	parameter int MAX_WEIGHTS = sss_pkg::DEF_MAX_WEIGHTS,
	parameter int WEIGHT_BITS = sss_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sss_pkg::sss_cmd_t                   cmd,
	output sss_pkg::sss_stat_t                       stat,
	input  wire logic [sss_pkg::WEIGHT_IN_W-1:0]     weight_value,
	input  wire logic signed [sss_pkg::TARGET_W-1:0] target_mass,
	output logic                                     found,
	output logic [sss_pkg::INDEX_W-1:0]              weight_index,
	output logic signed [sss_pkg::COEF_W-1:0]        coefficient,
	output logic                                     last,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);
	import sss_pkg::*;

	localparam int CNT_W = $clog2(MAX_WEIGHTS + 1);
	localparam int ADR_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
	localparam int REM_W = WEIGHT_BITS + CNT_W;
	localparam int GAP_W = ((REM_W > TARGET_W) ? REM_W : TARGET_W) + 3;

	logic [WEIGHT_BITS-1:0] wmem [MAX_WEIGHTS];
	logic [REM_W-1:0]       rmem [MAX_WEIGHTS+1];
	logic [COEF_W-1:0]      cmem [MAX_WEIGHTS];

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        d_q;
	logic [REM_W-1:0]        acc_q;
	logic signed [GAP_W-1:0] gap_q;
	logic [WEIGHT_BITS-1:0]  w_rd_q;
	logic [REM_W-1:0]        rem_rd_q;
	logic [COEF_W-1:0]       coef_rd_q;
	logic                    out_vld_q;
	logic                    found_q;
	logic [INDEX_W-1:0]      index_q;
	logic [COEF_W-1:0]       coef_q;
	logic                    last_q;

	logic [CNT_W-1:0]                 idx_m1;
	logic [CNT_W-1:0]                 d_m1;
	logic [ADR_W-1:0]                 w_addr;
	logic [ADR_W-1:0]                 c_addr;
	logic [REM_W-1:0]                 acc_nx;
	logic signed [GAP_W-1:0]          w_gap;
	logic signed [GAP_W-1:0]          rem_gap;
	logic signed [GAP_W-1:0]          gap_plus_rem;
	logic [WEIGHT_BITS+WEIGHT_IN_W-1:0] wv_ext;
	logic [CNT_W+INDEX_W-1:0]         idx_ext;
	logic                             full;
	logic                             emit_last;
	logic                             out_free;

	assign idx_m1       = idx_q - 1'b1;
	assign d_m1         = d_q - 1'b1;
	assign acc_nx       = acc_q + {{(REM_W-WEIGHT_BITS){1'b0}}, w_rd_q};
	assign w_gap        = $signed({{(GAP_W-WEIGHT_BITS){1'b0}}, w_rd_q});
	assign rem_gap      = $signed({{(GAP_W-REM_W){1'b0}}, rem_rd_q});
	assign gap_plus_rem = gap_q + rem_gap;
	assign wv_ext       = {{WEIGHT_BITS{1'b0}}, weight_value};
	assign idx_ext      = {{INDEX_W{1'b0}}, idx_q};
	assign full         = (count_q == CNT_W'(MAX_WEIGHTS));
	assign emit_last    = (count_q == '0) || (idx_q == count_q - 1'b1);
	assign out_free     = !out_vld_q || out_ready;

	always_comb begin
		if (cmd.sweep_rd) begin
			w_addr = idx_m1[ADR_W-1:0];
		end else if (cmd.back_rd) begin
			w_addr = d_m1[ADR_W-1:0];
		end else begin
			w_addr = d_q[ADR_W-1:0];
		end
	end

	assign c_addr = cmd.emit_rd ? idx_q[ADR_W-1:0] : d_m1[ADR_W-1:0];

	// weight store
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			wmem[count_q[ADR_W-1:0]] <= wv_ext[WEIGHT_BITS-1:0];
		end
		if (cmd.sweep_rd || cmd.enter_rd || cmd.back_rd) begin
			w_rd_q <= wmem[w_addr];
		end
	end

	// suffix sums of the weights, used to cut hopeless branches
	always_ff @(posedge clk) begin
		if (cmd.solve_start) begin
			rmem[count_q] <= '0;
		end else if (cmd.sweep_wr) begin
			rmem[idx_m1] <= acc_nx;
		end
		if (cmd.enter_rd) begin
			rem_rd_q <= rmem[d_q];
		end
	end

	// coefficient stack
	always_ff @(posedge clk) begin
		if (cmd.descend) begin
			cmem[d_q[ADR_W-1:0]] <= COEF_NEG;
		end else if (cmd.next_coef) begin
			cmem[d_q[ADR_W-1:0]] <= (coef_rd_q == COEF_NEG) ? COEF_ZERO : COEF_POS;
		end
		if (cmd.back_rd || cmd.emit_rd) begin
			coef_rd_q <= cmem[c_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			d_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clear_list) begin
				count_q <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + 1'b1;
			end

			if (cmd.solve_start) begin
				idx_q <= count_q;
			end else if (cmd.sweep_wr) begin
				idx_q <= idx_m1;
			end else if (cmd.emit_start) begin
				idx_q <= '0;
			end else if (cmd.load_found) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.solve_start) begin
				d_q <= '0;
			end else if (cmd.descend || cmd.next_coef) begin
				d_q <= d_q + 1'b1;
			end else if (cmd.back_rd) begin
				d_q <= d_m1;
			end

			if (cmd.load_found || cmd.load_fail) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// gap holds target minus running sum
	always_ff @(posedge clk) begin
		if (cmd.solve_start) begin
			acc_q <= '0;
			gap_q <= GAP_W'(target_mass);
		end else begin
			if (cmd.sweep_wr) begin
				acc_q <= acc_nx;
			end
			if (cmd.descend || cmd.undo) begin
				gap_q <= gap_q + w_gap;
			end else if (cmd.next_coef) begin
				gap_q <= gap_q - w_gap;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_found) begin
			found_q <= 1'b1;
			index_q <= idx_ext[INDEX_W-1:0];
			coef_q  <= (count_q == '0) ? COEF_ZERO : coef_rd_q;
			last_q  <= emit_last;
		end else if (cmd.load_fail) begin
			found_q <= 1'b0;
			index_q <= '0;
			coef_q  <= COEF_ZERO;
			last_q  <= 1'b1;
		end
	end

	assign stat.idx_zero  = (idx_q == '0);
	assign stat.d_zero    = (d_q == '0);
	assign stat.at_end    = (d_q == count_q);
	assign stat.gap_zero  = (gap_q == '0);
	assign stat.prune     = (gap_q > rem_gap) || (gap_plus_rem < 0);
	assign stat.coef_pos  = (coef_rd_q == COEF_POS);
	assign stat.emit_last = emit_last;
	assign stat.out_free  = out_free;

	assign found        = found_q;
	assign weight_index = index_q;
	assign coefficient  = $signed(coef_q);
	assign last         = last_q;
	assign out_valid    = out_vld_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WEIGHTS))
		else $error("weight count beyond capacity");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.descend || cmd.next_coef || cmd.back_rd || cmd.enter_rd) |-> d_q <= count_q)
		else $error("search depth beyond loaded weights");

	a_descend_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.descend |-> d_q != count_q)
		else $error("descend past the last weight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_found || cmd.load_fail) |-> out_free)
		else $error("result register overwritten before transaction");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_found || cmd.load_fail) |=> out_vld_q)
		else $error("loaded result not presented");

endmodule
`default_nettype wire

### hdl/signed_subset_sum_search.sv
// Top level: signed subset-sum search over loaded weights with coefficients -1, 0, +1.
// Clear and append transactions leave the request side ready.
// Solve: a suffix-sum sweep over the list, then a depth-first search that enters nodes and pops
// on backtrack, then the results, one per weight, each waiting for a free result register.
// One request is worked on at a time; the result register lets the next request enter early.
// Asynchronous reset empties the weight list and idles; stores hold garbage until written.
`default_nettype none
module signed_subset_sum_search #(
	parameter int MAX_WEIGHTS = sss_pkg::DEF_MAX_WEIGHTS,
	parameter int WEIGHT_BITS = sss_pkg::DEF_WEIGHT_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sss_req_if.sink   request,
	sss_rsp_if.source result
);
	import sss_pkg::*;

	sss_cmd_t  cmd;
	sss_stat_t stat;

	sss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_command (request.command),
		.stat       (stat),
		.in_ready   (request.ready),
		.cmd        (cmd)
	);

	sss_dp #(
		.MAX_WEIGHTS (MAX_WEIGHTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.weight_value (request.weight_value),
		.target_mass  (request.target_mass),
		.found        (result.found),
		.weight_index (result.weight_index),
		.coefficient  (result.coefficient),
		.last         (result.last),
		.out_valid    (result.valid),
		.out_ready    (result.ready)
	);

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for signed_subset_sum_search: queued stimulus, driver, monitor, predictor.
`timescale 1ns / 1ps
module testbench;
	import sss_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         SLOTS       = DEF_MAX_WEIGHTS;
	localparam int         ITEM_GOAL   = 370;
	localparam int         QUIET_LIMIT = 100000;
	localparam int         STALL_LEN   = 400;

	typedef struct packed {
		logic [1:0]                command;
		logic [WEIGHT_IN_W-1:0]    weight;
		logic signed [TARGET_W-1:0] target;
	} scale_req_t;

	typedef struct packed {
		logic                     found;
		logic [INDEX_W-1:0]       index;
		logic signed [COEF_W-1:0] coef;
		logic                     last;
	} coef_report_t;

	logic clk = 1'b0;
	logic arst_n;

	sss_req_if req_ch ();
	sss_rsp_if rsp_ch ();

	signed_subset_sum_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch)
	);

	always #5 clk = ~clk;

	scale_req_t   request_queue[$];
	coef_report_t coef_expect[$];
	int           fail_count   = 0;
	int           cycle_count  = 0;
	int           quiet_cycles = 0;
	int           results_seen = 0;
	int           hold_left    = 0;
	bit           stall_done   = 1'b0;
	wire          calm         = cycle_count >= 20000 && cycle_count < 40000;

	// predictor state
	logic [WEIGHT_IN_W-1:0]   pan_weights[SLOTS];
	int                       pan_count = 0;
	logic signed [COEF_W-1:0] pan_coefs[SLOTS];
	longint                   pan_suffix[SLOTS+1];
	longint                   pan_goal;
	longint                   pan_sum;

	// depth-first: -1, 0, +1 per weight, skip branches that cannot reach the goal
	function automatic bit balance_search(int d);
		longint gap;
		if (d >= pan_count)
			return pan_sum == pan_goal;
		gap = pan_goal - pan_sum;
		if (gap < 0)
			gap = -gap;
		if (gap > pan_suffix[d])
			return 1'b0;
		for (int c = -1; c <= 1; c++) begin
			pan_coefs[d] = COEF_W'(c);
			pan_sum += c * longint'(pan_weights[d]);
			if (balance_search(d + 1))
				return 1'b1;
			pan_sum -= c * longint'(pan_weights[d]);
		end
		return 1'b0;
	endfunction

	task automatic balance_step(scale_req_t r);
		int i;
		case (r.command)
			CMD_CLEAR: begin
				pan_count = 0;
			end
			CMD_APPEND: begin
				if (pan_count < SLOTS) begin
					pan_weights[pan_count] = r.weight;
					pan_count++;
				end
			end
			CMD_SOLVE: begin
				pan_goal = $signed(r.target);
				pan_suffix[pan_count] = 0;
				for (i = pan_count - 1; i >= 0; i--)
					pan_suffix[i] = pan_suffix[i+1] + longint'(pan_weights[i]);
				pan_sum = 0;
				if (!balance_search(0))
					coef_expect.push_back(coef_report_t'{1'b0, 4'd0, COEF_ZERO, 1'b1});
				else if (pan_count == 0)
					coef_expect.push_back(coef_report_t'{1'b1, 4'd0, COEF_ZERO, 1'b1});
				else
					for (i = 0; i < pan_count; i++)
						coef_expect.push_back(coef_report_t'{1'b1, INDEX_W'(i), pan_coefs[i],
							i == pan_count - 1});
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		scale_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				balance_step(scale_req_t'{req_ch.command, req_ch.weight_value,
					req_ch.target_mass});
			if (!req_ch.valid || req_ch.ready) begin
				if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
					nxt = request_queue.pop_front();
					req_ch.command      <= nxt.command;
					req_ch.weight_value <= nxt.weight;
					req_ch.target_mass  <= nxt.target;
					req_ch.valid        <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		coef_report_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen <= results_seen + 1;
				if (coef_expect.size() == 0) begin
					$error("unexpected result transaction: found %0d index %0d coef %0d last %0d",
						rsp_ch.found, rsp_ch.weight_index, rsp_ch.coefficient, rsp_ch.last);
					fail_count++;
				end else begin
					want = coef_expect.pop_front();
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						fail_count++;
					end
					if (rsp_ch.weight_index !== want.index) begin
						$error("weight_index: expected %0d, got %0d", want.index,
							rsp_ch.weight_index);
						fail_count++;
					end
					if (rsp_ch.coefficient !== want.coef) begin
						$error("coefficient: expected %0d, got %0d", want.coef,
							rsp_ch.coefficient);
						fail_count++;
					end
					if (rsp_ch.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!stall_done && results_seen >= 30) begin
				stall_done   <= 1'b1;
				hold_left    <= STALL_LEN;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || $urandom_range(99) >= 21;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && !((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	int counted = 0;

	task automatic queue_item(logic [1:0] cmd, logic [15:0] w, logic signed [20:0] t);
		request_queue.push_back(scale_req_t'{cmd, w, t});
		if (cmd != CMD_UNUSED)
			counted++;
	endtask

	function automatic logic [15:0] pick_weight();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5)
			return 16'($urandom());
		else if (sel < 8)
			return 16'($urandom_range(15));
		return 16'($urandom_range(255));
	endfunction

	initial begin
		int                 n;
		int                 k;
		int                 sel;
		int                 gen_count;
		longint             acc;
		logic [15:0]        w;
		logic [15:0]        gen_w[SLOTS];
		logic signed [20:0] t;

		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_CLEAR;
		req_ch.weight_value = '0;
		req_ch.target_mass  = '0;
		rsp_ch.ready        = 1'b0;

		// empty list: zero target balances, nonzero does not
		queue_item(CMD_CLEAR, 16'hFFFF, 21'h1FFFFF);
		queue_item(CMD_SOLVE, 16'h0000, 21'sd0);
		queue_item(CMD_SOLVE, 16'hFFFF, 21'sd5);
		queue_item(CMD_UNUSED, 16'hFFFF, 21'h1FFFFF);
		// full list of max weights, one extra append dropped
		for (k = 0; k < SLOTS + 1; k++)
			queue_item(CMD_APPEND, 16'hFFFF, 21'h0AAAAA);
		queue_item(CMD_SOLVE, 16'h0000, 21'sd1048575);
		queue_item(CMD_SOLVE, 16'h0000, -21'sd1048560);
		queue_item(CMD_SOLVE, 16'h0000, -21'sd1048576);
		gen_count = SLOTS;

		while (counted < ITEM_GOAL) begin
			if (gen_count > 7 || $urandom_range(9) != 0) begin
				queue_item(CMD_CLEAR, 16'($urandom()), 21'($urandom()));
				gen_count = 0;
			end
			if ($urandom_range(19) == 0) begin
				// full list from empty, so the all -1 and all +1 targets stay quick
				if (gen_count != 0) begin
					queue_item(CMD_CLEAR, 16'($urandom()), 21'($urandom()));
					gen_count = 0;
				end
				acc = 0;
				for (k = 0; k < SLOTS + $urandom_range(2); k++) begin
					w = 16'($urandom());
					queue_item(CMD_APPEND, w, 21'($urandom()));
					if (gen_count < SLOTS) begin
						gen_w[gen_count] = w;
						gen_count++;
						acc += w;
					end
				end
				queue_item(CMD_SOLVE, 16'($urandom()), 21'(-acc));
				queue_item(CMD_SOLVE, 16'($urandom()), 21'(acc));
			end else begin
				n = $urandom_range(7 - gen_count);
				for (k = 0; k < n; k++) begin
					w = pick_weight();
					queue_item(CMD_APPEND, w, 21'($urandom()));
					gen_w[gen_count] = w;
					gen_count++;
				end
				repeat ($urandom_range(1, 3)) begin
					sel = $urandom_range(19);
					if (sel < 12) begin
						acc = 0;
						for (k = 0; k < gen_count; k++)
							case ($urandom_range(2))
								0: acc -= gen_w[k];
								2: acc += gen_w[k];
								default: ;
							endcase
						t = 21'(acc);
					end else if (sel < 17) begin
						t = 21'($urandom());
					end else begin
						t = 21'($signed($urandom_range(40)) - 20);
					end
					queue_item(CMD_SOLVE, 16'($urandom()), t);
				end
			end
			if ($urandom_range(19) == 0)
				queue_item(CMD_UNUSED, 16'($urandom()), 21'($urandom()));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (coef_expect.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
hdl/sss_pkg.sv
hdl/sss_ifs.sv
hdl/sss_ctrl.sv
hdl/sss_dp.sv
hdl/signed_subset_sum_search.sv
dv/testbench.sv
